/* hdl/rpfa_pkg.sv */
// Shared constants, types and codes of the reference-counted page frame allocator.
package rpfa_pkg;

  // Sizing
  localparam int unsigned NUM_PAGES  = 32768;
  localparam int unsigned PAGE_BYTES = 4096;

  // Field widths
  localparam int unsigned ADDR_W     = 56;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Derived widths
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PN_W       = ADDR_W - PAGE_SHIFT;
  localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W    = $clog2(NUM_PAGES + 1);

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PN_W-1:0]    pn_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [CNT_W-1:0]   count_t;

  // Register reset values
  localparam addr_t BASE_RST = ADDR_W'(64'h0000_0000_8000_0000);
  localparam addr_t FIRST_FREE_RST = ADDR_W'(64'h0000_0000_8000_0000);
  localparam addr_t TOP_RST = ADDR_W'(64'h0000_0000_8800_0000);

  localparam count_t CNT_MAX = '1;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_FREE   = 3'd2,
    OP_INCREF = 3'd3,
    OP_QUERY  = 3'd4
  } opcode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_ADDR  = 3'd1,
    STAT_BAD_COUNT = 3'd2,
    STAT_NO_MEM    = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE       = 2'd0,
    CFG_FIRST_FREE = 2'd1,
    CFG_TOP        = 2'd2
  } cfg_idx_e;

endpackage

/* hdl/rpfa_ifs.sv */
// Channel interfaces of the page frame allocator: request, response and config write.
interface rpfa_req_if;
  logic                           valid;
  logic                           ready;
  logic [rpfa_pkg::OP_W-1:0]      opcode;
  rpfa_pkg::addr_t                page_address;

  modport source (output valid, opcode, page_address, input ready);
  modport sink   (input valid, opcode, page_address, output ready);
endinterface

interface rpfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rpfa_pkg::STATUS_W-1:0]  status;
  rpfa_pkg::addr_t                alloc_address;
  rpfa_pkg::count_t               ref_count;

  modport source (output valid, status, alloc_address, ref_count, input ready);
  modport sink   (input valid, status, alloc_address, ref_count, output ready);
endinterface

interface rpfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rpfa_pkg::CFG_IDX_W-1:0] index;
  rpfa_pkg::addr_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/refcounted_page_frame_allocator.sv */
// Top level: free-page stack and per-page reference counts held in two RAMs.
// Steps from request beat to result: check, fetch, exec, put for free, incref and query; check,
//   alloc, put for alloc; check, fetch, put for rejected addresses; check, put for an
//   empty-stack alloc or an unknown opcode. A new request is taken only back in idle.
// Init sweeps every count entry before its result.
// Reset: a clearing sweep zeroes every count entry; config always taken.
module refcounted_page_frame_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpfa_req_if.sink   req_i,
  rpfa_rsp_if.source rsp_o,
  rpfa_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_FETCH,
    S_EXEC,
    S_INIT_A,
    S_INIT_B,
    S_PUT
  } state_e;

  state_e                    state_q;
  rpfa_pkg::opcode_e         op_q;
  rpfa_pkg::addr_t           pa_q;
  rpfa_pkg::addr_t           base_q;
  rpfa_pkg::addr_t           first_free_q;
  rpfa_pkg::addr_t           top_q;
  rpfa_pkg::depth_t          depth_q;
  rpfa_pkg::depth_t          sweep_q;
  rpfa_pkg::depth_t          i0_q;
  rpfa_pkg::depth_t          iend_q;
  logic                      sweep_push_q;
  logic [rpfa_pkg::PN_W:0]   p0pn_q;
  rpfa_pkg::idx_t            idx_q;
  logic                      addr_ok_q;
  rpfa_pkg::status_e         res_status_q;
  rpfa_pkg::addr_t           res_addr_q;
  rpfa_pkg::count_t          res_count_q;
  logic                      out_valid_q;
  rpfa_pkg::status_e         out_status_q;
  rpfa_pkg::addr_t           out_addr_q;
  rpfa_pkg::count_t          out_count_q;

  // RAM ports
  logic                      cnt_we;
  rpfa_pkg::idx_t            cnt_waddr;
  rpfa_pkg::count_t          cnt_wdata;
  logic                      cnt_re;
  rpfa_pkg::count_t          cnt_rdata;
  logic                      stk_we;
  rpfa_pkg::idx_t            stk_waddr;
  rpfa_pkg::idx_t            stk_wdata;
  logic                      stk_re;
  rpfa_pkg::idx_t            stk_rdata;

  // Address decode
  rpfa_pkg::pn_t             bpn;
  logic [rpfa_pkg::PN_W:0]   pdiff;
  logic                      in_range;
  logic                      aligned;
  logic                      ge_first_free;
  logic [rpfa_pkg::ADDR_W:0] ff_round;
  logic [rpfa_pkg::PN_W+1:0] i0_diff;
  logic [rpfa_pkg::PN_W+1:0] iend_diff;
  rpfa_pkg::depth_t          depth_m1;
  rpfa_pkg::depth_t          sweep_off;
  logic                      push_hit;
  logic                      sweep_last;
  rpfa_pkg::pn_t             alloc_pn;
  rpfa_pkg::status_e         ex_status;
  rpfa_pkg::count_t          ex_count;
  logic                      req_beat;
  logic                      out_free;

  // Page count at or above NUM_PAGES saturates; negative means no pages.
  function automatic rpfa_pkg::depth_t clamp_pages(input logic [rpfa_pkg::PN_W+1:0] v);
    if (v[rpfa_pkg::PN_W+1]) begin
      return '0;
    end else if (v >= (rpfa_pkg::PN_W+2)'(rpfa_pkg::NUM_PAGES)) begin
      return rpfa_pkg::DEPTH_W'(rpfa_pkg::NUM_PAGES);
    end else begin
      return v[rpfa_pkg::DEPTH_W-1:0];
    end
  endfunction

  // Base is taken page aligned: compare in page numbers where that is exact
  assign bpn           = base_q[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT];
  assign pdiff         = {1'b0, pa_q[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT]} - {1'b0, bpn};
  assign in_range      = !pdiff[rpfa_pkg::PN_W]
                         && (pdiff[rpfa_pkg::PN_W-1:0] < rpfa_pkg::PN_W'(rpfa_pkg::NUM_PAGES))
                         && (pa_q < top_q);
  assign aligned       = (pa_q[rpfa_pkg::PAGE_SHIFT-1:0] == '0);
  assign ge_first_free = (pa_q >= first_free_q);

  // Init range: first page index after the kernel image, one past the last whole page
  assign ff_round  = {1'b0, first_free_q} + (rpfa_pkg::ADDR_W+1)'(rpfa_pkg::PAGE_BYTES - 1);
  assign i0_diff   = {1'b0, p0pn_q} - {2'b0, bpn};
  assign iend_diff = {2'b0, top_q[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT]} - {2'b0, bpn};

  // Sweep bookkeeping
  assign depth_m1   = depth_q - rpfa_pkg::DEPTH_W'(1);
  assign sweep_off  = sweep_q - i0_q;
  assign push_hit   = sweep_push_q && (sweep_q >= i0_q) && (sweep_q < iend_q);
  assign sweep_last = (sweep_q == rpfa_pkg::DEPTH_W'(rpfa_pkg::NUM_PAGES - 1));
  assign alloc_pn   = bpn + rpfa_pkg::PN_W'(stk_rdata);

  assign req_beat    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.alloc_address = out_addr_q;
  assign rsp_o.ref_count     = out_count_q;

  // Count update for free, incref and query
  always_comb begin
    ex_status = rpfa_pkg::STAT_OK;
    ex_count  = '0;
    unique case (op_q)
      rpfa_pkg::OP_FREE: begin
        if (cnt_rdata == '0) begin
          ex_status = rpfa_pkg::STAT_BAD_COUNT;
        end else begin
          ex_count = cnt_rdata - rpfa_pkg::CNT_W'(1);
        end
      end
      rpfa_pkg::OP_INCREF: begin
        if (cnt_rdata == '0) begin
          ex_status = rpfa_pkg::STAT_BAD_COUNT;
        end else if (cnt_rdata == rpfa_pkg::CNT_MAX) begin
          ex_status = rpfa_pkg::STAT_OVERFLOW;
          ex_count  = rpfa_pkg::CNT_MAX;
        end else begin
          ex_count = cnt_rdata + rpfa_pkg::CNT_W'(1);
        end
      end
      rpfa_pkg::OP_QUERY: begin
        ex_count = cnt_rdata;
      end
      default: begin
        ex_count = '0;
      end
    endcase
  end

  // RAM access per state
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = depth_q[rpfa_pkg::IDX_W-1:0];
    stk_wdata = idx_q;
    stk_re    = 1'b0;
    unique case (state_q)
      S_SWEEP: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_q[rpfa_pkg::IDX_W-1:0];
        stk_we    = push_hit;
        stk_waddr = sweep_off[rpfa_pkg::IDX_W-1:0];
        stk_wdata = sweep_q[rpfa_pkg::IDX_W-1:0];
      end
      S_CHECK: begin
        stk_re = (op_q == rpfa_pkg::OP_ALLOC) && (depth_q != '0);
      end
      S_ALLOC: begin
        cnt_we    = 1'b1;
        cnt_waddr = stk_rdata;
        cnt_wdata = rpfa_pkg::CNT_W'(1);
      end
      S_FETCH: begin
        cnt_re = addr_ok_q;
      end
      S_EXEC: begin
        cnt_wdata = ex_count;
        cnt_we    = (ex_status == rpfa_pkg::STAT_OK) && (op_q != rpfa_pkg::OP_QUERY);
        stk_we    = (op_q == rpfa_pkg::OP_FREE) && (ex_status == rpfa_pkg::STAT_OK)
                    && (ex_count == '0)
                    && (depth_q < rpfa_pkg::DEPTH_W'(rpfa_pkg::NUM_PAGES));
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  // Stack read address: the entry below the top
  rpfa_pkg::idx_t stk_raddr;
  assign stk_raddr = depth_m1[rpfa_pkg::IDX_W-1:0];

  rpfa_ram #(
    .WIDTH (rpfa_pkg::CNT_W),
    .DEPTH (rpfa_pkg::NUM_PAGES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (idx_q),
    .rdata_o (cnt_rdata)
  );

  rpfa_ram #(
    .WIDTH (rpfa_pkg::IDX_W),
    .DEPTH (rpfa_pkg::NUM_PAGES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Sequencer, config registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      base_q       <= rpfa_pkg::BASE_RST;
      first_free_q <= rpfa_pkg::FIRST_FREE_RST;
      top_q        <= rpfa_pkg::TOP_RST;
      depth_q      <= '0;
      sweep_q      <= '0;
      sweep_push_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // Config beats
      if (cfg_i.valid) begin
        case (cfg_i.index)
          rpfa_pkg::CFG_BASE:       base_q       <= cfg_i.data;
          rpfa_pkg::CFG_FIRST_FREE: first_free_q <= cfg_i.data;
          rpfa_pkg::CFG_TOP:        top_q        <= cfg_i.data;
          default: ;
        endcase
      end

      // Response beat taken; the put state refills the register on its own
      if (out_valid_q && rsp_o.ready && (state_q != S_PUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_SWEEP: begin
          sweep_q <= sweep_q + rpfa_pkg::DEPTH_W'(1);
          if (push_hit) begin
            depth_q <= depth_q + rpfa_pkg::DEPTH_W'(1);
          end
          if (sweep_last) begin
            res_status_q <= rpfa_pkg::STAT_OK;
            res_addr_q   <= '0;
            res_count_q  <= '0;
            state_q      <= sweep_push_q ? S_PUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_beat) begin
            op_q    <= rpfa_pkg::opcode_e'(req_i.opcode);
            pa_q    <= req_i.page_address;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_status_q <= ((op_q == rpfa_pkg::OP_ALLOC) && (depth_q == '0))
                          ? rpfa_pkg::STAT_NO_MEM : rpfa_pkg::STAT_OK;
          res_addr_q   <= '0;
          res_count_q  <= '0;
          idx_q        <= pdiff[rpfa_pkg::IDX_W-1:0];
          addr_ok_q    <= (op_q == rpfa_pkg::OP_FREE)
                          ? (in_range && aligned && ge_first_free) : in_range;
          unique case (op_q)
            rpfa_pkg::OP_INIT: begin
              state_q <= S_INIT_A;
            end
            rpfa_pkg::OP_ALLOC: begin
              if (depth_q == '0) begin
                state_q <= S_PUT;
              end else begin
                depth_q <= depth_m1;
                state_q <= S_ALLOC;
              end
            end
            rpfa_pkg::OP_FREE, rpfa_pkg::OP_INCREF, rpfa_pkg::OP_QUERY: begin
              state_q <= S_FETCH;
            end
            default: begin
              state_q <= S_PUT;
            end
          endcase
        end
        S_ALLOC: begin
          res_addr_q  <= {alloc_pn, rpfa_pkg::PAGE_SHIFT'(0)};
          res_count_q <= rpfa_pkg::CNT_W'(1);
          state_q     <= S_PUT;
        end
        S_FETCH: begin
          if (addr_ok_q) begin
            state_q <= S_EXEC;
          end else begin
            // Out-of-range query reads as count zero with ok status
            if (op_q != rpfa_pkg::OP_QUERY) begin
              res_status_q <= rpfa_pkg::STAT_BAD_ADDR;
            end
            state_q <= S_PUT;
          end
        end
        S_EXEC: begin
          res_status_q <= ex_status;
          res_count_q  <= (ex_status == rpfa_pkg::STAT_BAD_COUNT) ? '0 : ex_count;
          if (stk_we) begin
            depth_q <= depth_q + rpfa_pkg::DEPTH_W'(1);
          end
          state_q <= S_PUT;
        end
        S_INIT_A: begin
          p0pn_q  <= ff_round[rpfa_pkg::ADDR_W:rpfa_pkg::PAGE_SHIFT];
          depth_q <= '0;
          state_q <= S_INIT_B;
        end
        S_INIT_B: begin
          i0_q         <= clamp_pages(i0_diff);
          iend_q       <= clamp_pages(iend_diff);
          sweep_q      <= '0;
          sweep_push_q <= 1'b1;
          state_q      <= S_SWEEP;
        end
        S_PUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_addr_q   <= res_addr_q;
            out_count_q  <= res_count_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Stack depth never passes the number of pages
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= rpfa_pkg::DEPTH_W'(rpfa_pkg::NUM_PAGES))
    else $error("free stack depth above page count");

  // A pop only reads a stack that holds something
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_re |-> (depth_q != '0))
    else $error("stack pop while empty");

  // A push only writes a stack with room
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stk_we && (state_q == S_EXEC)) |-> (depth_q < rpfa_pkg::DEPTH_W'(rpfa_pkg::NUM_PAGES)))
    else $error("stack push while full");

  // A request beat starts the address check next cycle
  a_req_to_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat |=> (state_q == S_CHECK))
    else $error("request beat not followed by check");

  // A response beat only comes out of the put state
  a_rsp_from_put : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_PUT))
    else $error("response raised outside put state");

endmodule

/* hdl/rpfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
